FILE: rtl/vertex_linear_gradient_blend_assert.svh
// Assertion macros for the gradient blend block.
`ifndef VERTEX_LINEAR_GRADIENT_BLEND_ASSERT_SVH
`define VERTEX_LINEAR_GRADIENT_BLEND_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define VLGB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlgb assertion failed");
// Next-cycle implication.
`define VLGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlgb assertion failed");
`else
`define VLGB_ASSERT_NOW(label, ante, cons)
`define VLGB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/vlgb_pkg.sv
package vlgb_pkg;

  // Blend modes
  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_OVER = 2'd2,
    MODE_SUB  = 2'd3
  } blend_mode_t;

  // Register indexes on the config port
  typedef enum logic [2:0] {
    REG_PLANE_NORMAL   = 3'd0,
    REG_PLANE_OFFSET   = 3'd1,
    REG_RAY_LENGTH     = 3'd2,
    REG_INVERSE_LENGTH = 3'd3,
    REG_COLOR_START    = 3'd4,
    REG_COLOR_END      = 3'd5,
    REG_BLEND_MODE     = 3'd6,
    REG_CAP_FLAGS      = 3'd7
  } reg_index_t;

  // 1.0 for the interpolation factor (16 fraction bits)
  localparam logic [16:0] T_ONE = 17'd65536;

  // Load enables for the blend lane stages
  typedef struct packed {
    logic en6;
    logic en7;
    logic en8;
  } lane_en_t;

  // Per-vertex data that rides along the pipe
  typedef struct packed {
    logic [31:0] orig;
    logic [31:0] grad;
    logic        skip;
    logic        last;
  } side_t;

  // Exact x/255 rounded down for x up to 255*255+127: (x + 1 + (x >> 8)) >> 8
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = 17'(x) + 17'd1 + 17'(x[15:8]);
    return acc[15:8];
  endfunction

endpackage

FILE: rtl/vlgb_lane.sv
// One color channel of the blend: mode op, divide, alpha lerp sum.
module vlgb_lane (
  input  logic                   clk,
  input  vlgb_pkg::lane_en_t     en,
  input  vlgb_pkg::blend_mode_t  mode,
  input  logic [7:0]             orig,
  input  logic [7:0]             grad,
  input  logic [7:0]             alpha,
  output logic [15:0]            sum
);

  logic [15:0] pre_nxt;
  logic [15:0] pre_r;
  logic [7:0]  o6_r, a6_r;
  logic [7:0]  d_nxt;
  logic [7:0]  d_r, o7_r, a7_r;
  logic [15:0] sum_nxt;
  logic [15:0] sum_r;

  // Stage 6: add/subtract clamp, or product plus rounding bias for multiply
  always_comb begin
    unique case (mode)
      vlgb_pkg::MODE_ADD: begin
        pre_nxt = (9'(orig) + 9'(grad) > 9'd255) ? 16'd255 : 16'(orig) + 16'(grad);
      end
      vlgb_pkg::MODE_MUL: begin
        pre_nxt = 16'(orig) * 16'(grad) + 16'd127;
      end
      vlgb_pkg::MODE_SUB: begin
        pre_nxt = (orig > grad) ? 16'(orig - grad) : 16'd0;
      end
      default: begin
        pre_nxt = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.en6) begin
      pre_r <= pre_nxt;
      o6_r  <= orig;
      a6_r  <= alpha;
    end
  end

  // Stage 7: finish the multiply rounding
  assign d_nxt = (mode == vlgb_pkg::MODE_MUL) ? vlgb_pkg::div255(pre_r) : pre_r[7:0];

  always_ff @(posedge clk) begin
    if (en.en7) begin
      d_r  <= d_nxt;
      o7_r <= o6_r;
      a7_r <= a6_r;
    end
  end

  // Stage 8: lerp numerator from original toward blended value
  assign sum_nxt = 16'(o7_r) * 16'(8'd255 - a7_r) + 16'(d_r) * 16'(a7_r) + 16'd127;

  always_ff @(posedge clk) begin
    if (en.en8) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

FILE: rtl/vertex_linear_gradient_blend.sv
// Linear gradient vertex color blend. Each request is one vertex (Q16.16
// position plus RGBA color); the block measures its signed distance to the
// configured plane, picks or interpolates the gradient color, blends it into
// the original color and returns one result per request. The datapath is a
// nine-stage pipeline: a new vertex is taken every cycle while the output
// is not stalled. Stall on the result side backs up only as far as the pipe
// is full; bubbles are squeezed out, so input is still taken while a finished
// result waits. The longest stage is the 31x31 distance-by-reciprocal
// multiply. Config registers may be written any time the pipe is empty;
// cfg_ready is always high.
module vertex_linear_gradient_blend (
  input  logic               clk,
  input  logic               rst_n,
  // config write port
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  // vertex requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_orig_red,
  input  logic [7:0]         in_orig_green,
  input  logic [7:0]         in_orig_blue,
  input  logic [7:0]         in_orig_alpha,
  input  logic               in_last_in,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_new_red,
  output logic [7:0]         out_new_green,
  output logic [7:0]         out_new_blue,
  output logic [7:0]         out_new_alpha,
  output logic               out_write_enable,
  output logic               out_last_out
);

  `include "vertex_linear_gradient_blend_assert.svh"

  // Config registers
  logic [47:0]           plane_normal_r;
  logic [31:0]           plane_offset_r;
  logic [30:0]           ray_length_r;
  logic [30:0]           inverse_length_r;
  logic [31:0]           color_start_r;
  logic [31:0]           color_end_r;
  vlgb_pkg::blend_mode_t blend_mode_r;
  logic [1:0]            cap_flags_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_normal_r   <= '0;
      plane_offset_r   <= '0;
      ray_length_r     <= '0;
      inverse_length_r <= '0;
      color_start_r    <= 32'h0000_00FF;
      color_end_r      <= 32'h0000_00FF;
      blend_mode_r     <= vlgb_pkg::MODE_MUL;
      cap_flags_r      <= '0;
    end else if (cfg_valid) begin
      unique case (vlgb_pkg::reg_index_t'(cfg_index))
        vlgb_pkg::REG_PLANE_NORMAL:   plane_normal_r   <= cfg_data;
        vlgb_pkg::REG_PLANE_OFFSET:   plane_offset_r   <= cfg_data[31:0];
        vlgb_pkg::REG_RAY_LENGTH:     ray_length_r     <= cfg_data[30:0];
        vlgb_pkg::REG_INVERSE_LENGTH: inverse_length_r <= cfg_data[30:0];
        vlgb_pkg::REG_COLOR_START:    color_start_r    <= cfg_data[31:0];
        vlgb_pkg::REG_COLOR_END:      color_end_r      <= cfg_data[31:0];
        vlgb_pkg::REG_BLEND_MODE:     blend_mode_r     <= vlgb_pkg::blend_mode_t'(cfg_data[1:0]);
        vlgb_pkg::REG_CAP_FLAGS:      cap_flags_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when the next one moves
  logic [8:1] vld_r;
  logic [9:1] rdy;
  logic       out_valid_r;

  always_comb begin
    rdy[9] = !out_valid_r || !out_stall;
    for (int k = 8; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[9]) begin
        out_valid_r <= vld_r[8];
      end
    end
  end

  vlgb_pkg::side_t sd_r [1:8];

  // Stage 1: coordinate times normal component
  logic signed [15:0] nx, ny, nz;
  logic signed [47:0] px_r, py_r, pz_r;
  logic signed [31:0] off_r;

  assign nx = $signed(plane_normal_r[47:32]);
  assign ny = $signed(plane_normal_r[31:16]);
  assign nz = $signed(plane_normal_r[15:0]);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      px_r          <= in_coord_x * nx;
      py_r          <= in_coord_y * ny;
      pz_r          <= in_coord_z * nz;
      off_r         <= $signed(plane_offset_r);
      sd_r[1].orig  <= {in_orig_red, in_orig_green, in_orig_blue, in_orig_alpha};
      sd_r[1].grad  <= '0;
      sd_r[1].skip  <= 1'b0;
      sd_r[1].last  <= in_last_in;
    end
  end

  // Stage 2: signed distance, 30 fraction bits
  logic signed [50:0] dist_nxt;
  logic signed [50:0] dist_r;

  assign dist_nxt = 51'(px_r) + 51'(py_r) + 51'(pz_r) - (51'(off_r) <<< 14);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dist_r  <= dist_nxt;
      sd_r[2] <= sd_r[1];
    end
  end

  // Stage 3: region compare and distance times reciprocal length
  logic [44:0] len_q;
  logic        le_zero, ge_len, gt_len;
  logic        skip3;
  logic [61:0] prod_nxt;
  logic [61:0] prod_r;
  logic        at_start_r, at_end_r;

  assign len_q   = {ray_length_r, 14'd0};
  assign le_zero = dist_r[50] || (dist_r == '0);
  assign ge_len  = !dist_r[50] && (dist_r[49:0] >= 50'(len_q));
  assign gt_len  = !dist_r[50] && (dist_r[49:0] > 50'(len_q));
  assign skip3   = (cap_flags_r[0] && dist_r[50]) ||
                   (!le_zero && cap_flags_r[1] && gt_len);
  assign prod_nxt = 62'(dist_r[44:14]) * 62'(inverse_length_r);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      prod_r     <= prod_nxt;
      at_start_r <= le_zero;
      at_end_r   <= !le_zero && ge_len;
      sd_r[3]    <= '{orig: sd_r[2].orig, grad: sd_r[2].grad, skip: skip3,
                      last: sd_r[2].last};
    end
  end

  // Stage 4: round and saturate t; ends force t to 0 or 1.0
  logic [46:0] t_round;
  logic [16:0] t_nxt;
  logic [16:0] t_r;

  assign t_round = 47'(prod_r[61:16]) + 47'(prod_r[15]);

  always_comb begin
    priority if (at_start_r) begin
      t_nxt = 17'd0;
    end else if (at_end_r || t_round > 47'(vlgb_pkg::T_ONE)) begin
      t_nxt = vlgb_pkg::T_ONE;
    end else begin
      t_nxt = t_round[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      t_r     <= t_nxt;
      sd_r[4] <= sd_r[3];
    end
  end

  // Stage 5: gradient color lerp, per channel
  logic [31:0] grad_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [24:0] gsum;
      gsum = 25'(color_start_r[31-8*i -: 8]) * 25'(vlgb_pkg::T_ONE - t_r) +
             25'(color_end_r[31-8*i -: 8]) * 25'(t_r) + 25'd32768;
      grad_nxt[31-8*i -: 8] = gsum[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sd_r[5] <= '{orig: sd_r[4].orig, grad: grad_nxt, skip: sd_r[4].skip,
                   last: sd_r[4].last};
    end
  end

  // Stages 6 to 8: one blend lane per rgb channel
  vlgb_pkg::lane_en_t lane_en;
  logic [15:0]        lane_sum [3];

  assign lane_en.en6 = rdy[6];
  assign lane_en.en7 = rdy[7];
  assign lane_en.en8 = rdy[8];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    vlgb_lane u_lane (
      .clk   (clk),
      .en    (lane_en),
      .mode  (blend_mode_r),
      .orig  (sd_r[5].orig[31-8*c -: 8]),
      .grad  (sd_r[5].grad[31-8*c -: 8]),
      .alpha (sd_r[5].grad[7:0]),
      .sum   (lane_sum[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sd_r[6] <= sd_r[5];
    end
    if (rdy[7]) begin
      sd_r[7] <= sd_r[6];
    end
    if (rdy[8]) begin
      sd_r[8] <= sd_r[7];
    end
  end

  // Stage 9: final divide and output select
  logic [31:0] res_nxt;
  logic [31:0] res_r;
  logic        we_r;
  logic        last_r;

  always_comb begin
    priority if (sd_r[8].skip) begin
      res_nxt = sd_r[8].orig;
    end else if (blend_mode_r == vlgb_pkg::MODE_OVER) begin
      res_nxt = sd_r[8].grad;
    end else begin
      res_nxt = {vlgb_pkg::div255(lane_sum[0]), vlgb_pkg::div255(lane_sum[1]),
                 vlgb_pkg::div255(lane_sum[2]), sd_r[8].orig[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      res_r  <= res_nxt;
      we_r   <= !sd_r[8].skip;
      last_r <= sd_r[8].last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_red      = res_r[31:24];
  assign out_new_green    = res_r[23:16];
  assign out_new_blue     = res_r[15:8];
  assign out_new_alpha    = res_r[7:0];
  assign out_write_enable = we_r;
  assign out_last_out     = last_r;

  // Checks
  `VLGB_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, vld_r[1])
  `VLGB_ASSERT_NEXT(a_s8_holds, vld_r[8] && !rdy[8], vld_r[8] && $stable(sd_r[8]))
  `VLGB_ASSERT_NOW(a_t_range, vld_r[4], t_r <= vlgb_pkg::T_ONE)
  `VLGB_ASSERT_NOW(a_skip_needs_cap, vld_r[4] && sd_r[4].skip, cap_flags_r != 2'd0)

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT    = 9;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 1450;
  localparam int QUIET_AFTER = 1300;
  localparam int HOLD_CYCLES = 80;

  // One vertex request and one color result
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       we;
    logic       last;
  } shade_t;

  // Full register set for one gradient setting
  typedef struct packed {
    logic [47:0]           normal;
    logic signed [31:0]    offset;
    logic [30:0]           len;
    logic [30:0]           inv;
    logic [31:0]           cstart;
    logic [31:0]           cend;
    vlgb_pkg::blend_mode_t mode;
    logic [1:0]            caps;
  } grad_cfg_t;

  typedef struct packed {
    logic [2:0] cfg_id;
    vertex_t    v;
    logic       typed;
    shade_t     want;
  } dir_row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [47:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic signed [31:0] in_coord_z = '0;
  logic [7:0]         in_orig_red = '0;
  logic [7:0]         in_orig_green = '0;
  logic [7:0]         in_orig_blue = '0;
  logic [7:0]         in_orig_alpha = '0;
  logic               in_last_in = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_new_red;
  logic [7:0]         out_new_green;
  logic [7:0]         out_new_blue;
  logic [7:0]         out_new_alpha;
  logic               out_write_enable;
  logic               out_last_out;

  vertex_linear_gradient_blend DUT (.*);

  // Shadow copy of the gradient registers
  logic [47:0]           m_normal = '0;
  logic signed [31:0]    m_offset = '0;
  logic [30:0]           m_len    = '0;
  logic [30:0]           m_inv    = '0;
  logic [31:0]           m_cstart = 32'h0000_00FF;
  logic [31:0]           m_cend   = 32'h0000_00FF;
  vlgb_pkg::blend_mode_t m_mode   = vlgb_pkg::MODE_MUL;
  logic [1:0]            m_caps   = '0;

  shade_t shade_q[$];
  shade_t got_want;

  int n_err = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_skip = 0;
  int n_cfg = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  bit hold_req = 1'b0;

  // Directed register settings; entry 0 matches the reset values
  grad_cfg_t dir_cfgs [6] = '{
    '{48'h0000_0000_0000, 32'sh0000_0000, 31'h0000_0000, 31'h0000_0000,
      32'h0000_00FF, 32'h0000_00FF, vlgb_pkg::MODE_MUL, 2'd0},
    '{48'h4000_0000_0000, 32'sh0000_0000, 31'h000A_0000, 31'd6554,
      32'hFF00_00FF, 32'h0000_FFFF, vlgb_pkg::MODE_OVER, 2'd3},
    '{48'h0000_4000_0000, 32'sh0000_0000, 31'h0000_0000, 31'h0000_0000,
      32'h1020_3080, 32'hF0E0_D040, vlgb_pkg::MODE_ADD, 2'd0},
    '{48'h0000_0000_4000, 32'sh0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
      32'h0000_0000, 32'hFFFF_FFFF, vlgb_pkg::MODE_MUL, 2'd0},
    '{48'h8000_8000_8000, 32'sh8000_0000, 31'h0001_0000, 31'h0001_0000,
      32'h8080_8080, 32'h40C0_20FF, vlgb_pkg::MODE_SUB, 2'd1},
    '{48'h7FFF_7FFF_7FFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0001,
      32'hFFFF_FFFF, 32'h0000_0000, vlgb_pkg::MODE_ADD, 2'd2}
  };

  // Directed vertices; typed results where they are obvious
  dir_row_t dir_tab [20] = '{
    // reset setting: black opaque multiply clears rgb, keeps alpha
    '{3'd0, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
      1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
    '{3'd0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
    // overwrite with both caps: before start, on start, on end, past end, mid-ray, extremes
    '{3'd1, '{32'hFFFF_0000, 32'h0, 32'h0, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0},
      1'b1, '{8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b0}},
    '{3'd1, '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 8'hAB, 8'hCD, 8'hEF, 8'h01, 1'b1},
      1'b1, '{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
    '{3'd1, '{32'h000A_0000, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      1'b1, '{8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0}},
    '{3'd1, '{32'h000A_0001, 32'h0, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
      1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1}},
    '{3'd1, '{32'h0005_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0},
      1'b0, '0},
    '{3'd1, '{32'h7FFF_FFFF, 32'h1234_5678, 32'h0, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0},
      1'b1, '{8'h01, 8'h02, 8'h03, 8'h04, 1'b0, 1'b0}},
    '{3'd1, '{32'h8000_0000, 32'h0, 32'hEDCB_A987, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 1'b1},
      1'b1, '{8'hFE, 8'hFD, 8'hFC, 8'hFB, 1'b0, 1'b1}},
    // zero ray length: zero distance takes the start, any positive the end
    '{3'd2, '{32'h0, 32'h0, 32'h0, 8'h40, 8'h80, 8'hC0, 8'h20, 1'b0}, 1'b0, '0},
    '{3'd2, '{32'h0, 32'h1, 32'h0, 8'h40, 8'h80, 8'hC0, 8'h20, 1'b1}, 1'b0, '0},
    '{3'd2, '{32'h0, 32'hFFFF_FFFF, 32'h0, 8'hF0, 8'h0F, 8'h99, 8'h66, 1'b0}, 1'b0, '0},
    // inverse length far too large: a unit distance saturates the factor at one
    '{3'd3, '{32'h0, 32'h0, 32'h0001_0000, 8'h80, 8'h7F, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
    '{3'd3, '{32'h0, 32'h0, 32'h0000_0001, 8'h80, 8'h7F, 8'hFF, 8'h00, 1'b1}, 1'b0, '0},
    // extreme normal and offset, subtract
    '{3'd4, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h90, 8'h10, 8'hFF, 8'h33, 1'b0},
      1'b0, '0},
    '{3'd4, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h90, 8'h10, 8'hFF, 8'h33, 1'b1},
      1'b0, '0},
    '{3'd4, '{32'h0, 32'h0, 32'h0, 8'hC8, 8'h64, 8'h32, 8'h19, 1'b0}, 1'b0, '0},
    // max positive normal and offset, add with saturation
    '{3'd5, '{32'h0, 32'h0, 32'h0, 8'h01, 8'h80, 8'hFF, 8'h7E, 1'b0}, 1'b0, '0},
    '{3'd5, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h55, 8'hAA, 8'h00, 8'hFF, 1'b1},
      1'b0, '0},
    '{3'd5, '{32'h4000_0000, 32'h4000_0000, 32'h0, 8'h33, 8'hCC, 8'h77, 8'h88, 1'b0}, 1'b0, '0}
  };

  // Expected color for one vertex under the current registers
  function automatic shade_t blend_vertex(vertex_t v);
    logic signed [15:0] nxs, nys, nzs;
    longint dist_v, len;
    longint unsigned d16, t, c0, c1;
    logic [7:0] orig [4];
    logic [7:0] grad [4];
    logic [7:0] res [4];
    int unsigned o, s, d, al;
    bit skip;
    shade_t sh;
    nxs = m_normal[47:32];
    nys = m_normal[31:16];
    nzs = m_normal[15:0];
    orig[0] = v.r;
    orig[1] = v.g;
    orig[2] = v.b;
    orig[3] = v.a;
    skip = 1'b0;
    dist_v = longint'(v.x) * longint'(nxs) + longint'(v.y) * longint'(nys) +
             longint'(v.z) * longint'(nzs) - longint'(m_offset) * 64'sd16384;
    len = longint'({33'd0, m_len}) * 64'sd16384;
    // pick start, end or interpolated gradient color
    if (dist_v <= 0) begin
      skip = m_caps[0] && (dist_v < 0);
      for (int i = 0; i < 4; i++) grad[i] = m_cstart[31 - 8 * i -: 8];
    end else if (dist_v >= len) begin
      skip = m_caps[1] && (dist_v > len);
      for (int i = 0; i < 4; i++) grad[i] = m_cend[31 - 8 * i -: 8];
    end else begin
      d16 = longint'(unsigned'(dist_v)) >> 14;
      t = (d16 * {33'd0, m_inv} + 64'd32768) >> 16;
      if (t > 64'd65536) t = 64'd65536;
      for (int i = 0; i < 4; i++) begin
        c0 = m_cstart[31 - 8 * i -: 8];
        c1 = m_cend[31 - 8 * i -: 8];
        grad[i] = 8'((c0 * (64'd65536 - t) + c1 * t + 64'd32768) >> 16);
      end
    end
    // blend into the original, then fade by gradient alpha
    if (skip) begin
      res = orig;
    end else if (m_mode == vlgb_pkg::MODE_OVER) begin
      res = grad;
    end else begin
      al = grad[3];
      for (int i = 0; i < 3; i++) begin
        o = orig[i];
        s = grad[i];
        case (m_mode)
          vlgb_pkg::MODE_ADD: d = (o + s > 255) ? 255 : o + s;
          vlgb_pkg::MODE_MUL: d = (o * s + 127) / 255;
          default:  d = (o > s) ? o - s : 0;
        endcase
        res[i] = 8'((o * (255 - al) + d * al + 127) / 255);
      end
      res[3] = orig[3];
    end
    sh.r = res[0];
    sh.g = res[1];
    sh.b = res[2];
    sh.a = res[3];
    sh.we = !skip;
    sh.last = v.last;
    return sh;
  endfunction

  function automatic logic [31:0] rand_coord(int k);
    logic [63:0] span;
    if (k >= 31) return $urandom;
    span = 64'd1 << (k + 1);
    return 32'((64'($urandom) % span) - (span >> 1));
  endfunction

  // Random register setting with coordinates of scale 2^k
  function automatic grad_cfg_t rand_setting(int k);
    grad_cfg_t c;
    logic [63:0] q;
    case ($urandom_range(0, 7))
      0: c.normal = '0;
      1: c.normal = {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                     $urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                     $urandom_range(0, 1) ? 16'h7FFF : 16'h8000};
      default: c.normal = {16'($urandom), 32'($urandom)};
    endcase
    c.offset = rand_coord(k);
    case ($urandom_range(0, 9))
      0: c.len = '0;
      1: c.len = 31'h7FFF_FFFF;
      default: c.len = (k >= 30) ? 31'($urandom) : 31'(64'($urandom) % (64'd1 << (k + 1)));
    endcase
    case ($urandom_range(0, 3))
      0, 1: begin
        if (c.len == 0) begin
          c.inv = 31'($urandom);
        end else begin
          q = 64'h1_0000_0000 / {33'd0, c.len};
          c.inv = (q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(q);
        end
      end
      2: c.inv = 31'($urandom);
      default: c.inv = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
    endcase
    c.cstart = $urandom;
    c.cend = $urandom;
    c.mode = vlgb_pkg::blend_mode_t'(2'($urandom_range(0, 3)));
    c.caps = 2'($urandom_range(0, 3));
    return c;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One register write request; cfg_valid stays up for a following write
  task automatic write_reg(vlgb_pkg::reg_index_t idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vlgb_pkg::REG_PLANE_NORMAL:   m_normal = val;
      vlgb_pkg::REG_PLANE_OFFSET:   m_offset = val[31:0];
      vlgb_pkg::REG_RAY_LENGTH:     m_len = val[30:0];
      vlgb_pkg::REG_INVERSE_LENGTH: m_inv = val[30:0];
      vlgb_pkg::REG_COLOR_START:    m_cstart = val[31:0];
      vlgb_pkg::REG_COLOR_END:      m_cend = val[31:0];
      vlgb_pkg::REG_BLEND_MODE:     m_mode = vlgb_pkg::blend_mode_t'(val[1:0]);
      default:                      m_caps = val[1:0];
    endcase
  endtask

  // Writes all eight registers; junk fills unused upper data bits
  task automatic program_regs(grad_cfg_t c, bit junk);
    logic [47:0] fill;
    fill = junk ? {16'($urandom), 32'($urandom)} : '0;
    write_reg(vlgb_pkg::REG_PLANE_NORMAL, c.normal);
    write_reg(vlgb_pkg::REG_PLANE_OFFSET, {fill[47:32], c.offset});
    write_reg(vlgb_pkg::REG_RAY_LENGTH, {fill[47:31], c.len});
    write_reg(vlgb_pkg::REG_INVERSE_LENGTH, {fill[47:31], c.inv});
    write_reg(vlgb_pkg::REG_COLOR_START, {fill[47:32], c.cstart});
    write_reg(vlgb_pkg::REG_COLOR_END, {fill[47:32], c.cend});
    write_reg(vlgb_pkg::REG_BLEND_MODE, {fill[47:2], c.mode});
    write_reg(vlgb_pkg::REG_CAP_FLAGS, {fill[47:2], c.caps});
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // Drain the pipe before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Offer one vertex request, with an optional idle burst first
  task automatic send_vertex(vertex_t v, bit typed, shade_t want);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= v.x;
    in_coord_y <= v.y;
    in_coord_z <= v.z;
    in_orig_red <= v.r;
    in_orig_green <= v.g;
    in_orig_blue <= v.b;
    in_orig_alpha <= v.a;
    in_last_in <= v.last;
    do @(posedge clk); while (in_stall);
    shade_q.push_back(typed ? want : blend_vertex(v));
    n_sent++;
  endtask

  // Result side: random stall bursts and one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_cnt = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_err++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (shade_q.size() == 0) begin
        $display("%0t: result with no request pending, actual %h %h %h %h we %b last %b",
                 $time, out_new_red, out_new_green, out_new_blue, out_new_alpha,
                 out_write_enable, out_last_out);
        n_err++;
      end else begin
        got_want = shade_q.pop_front();
        check_field("new_red", got_want.r, out_new_red);
        check_field("new_green", got_want.g, out_new_green);
        check_field("new_blue", got_want.b, out_new_blue);
        check_field("new_alpha", got_want.a, out_new_alpha);
        check_field("write_enable", 8'(got_want.we), 8'(out_write_enable));
        check_field("last_out", 8'(got_want.last), 8'(out_last_out));
        n_checked++;
        if (!got_want.we) n_skip++;
      end
    end
  end

  // Watchdog on lack of progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, shade_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [2:0] cur_cfg;
    grad_cfg_t rc;
    vertex_t rv;
    int k, cnt, phase, n_rand;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    gap_pct = 20;
    stall_pct = 20;
    cur_cfg = 3'd0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_id != cur_cfg) begin
        settle();
        cur_cfg = dir_tab[i].cfg_id;
        program_regs(dir_cfgs[cur_cfg], 1'b0);
      end
      send_vertex(dir_tab[i].v, dir_tab[i].typed, dir_tab[i].want);
    end

    // random settings, each followed by a burst of vertices
    n_rand = 0;
    phase = 0;
    while (n_rand < RAND_ITEMS) begin
      settle();
      k = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(2, 30);
      rc = rand_setting(k);
      program_regs(rc, $urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 10; stall_pct = 15; end
        default: begin gap_pct = 30; stall_pct = 35; end
      endcase
      // long output hold while the input keeps pushing
      if (phase == 1) begin
        gap_pct = 0;
        hold_req = 1'b1;
      end
      cnt = $urandom_range(40, 140);
      for (int j = 0; j < cnt && n_rand < RAND_ITEMS; j++) begin
        if (n_rand >= QUIET_AFTER) begin
          gap_pct = 0;
          stall_pct = 0;
        end
        if ($urandom_range(0, 6) == 0) begin
          rv.x = $urandom;
          rv.y = $urandom;
          rv.z = $urandom;
        end else begin
          rv.x = rand_coord(k);
          rv.y = rand_coord(k);
          rv.z = rand_coord(k);
        end
        if ($urandom_range(0, 9) == 0) begin
          rv.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          rv.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          rv.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          rv.a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
          rv.r = 8'($urandom);
          rv.g = 8'($urandom);
          rv.b = 8'($urandom);
          rv.a = 8'($urandom);
        end
        rv.last = ($urandom_range(0, 7) == 0);
        send_vertex(rv, 1'b0, '0);
        n_rand++;
      end
      phase++;
    end

    // drain
    in_valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);

    $display("Checked %0d vertex colors (%0d cap skips) across %0d register settings,",
             n_checked, n_skip, n_cfg);
    $display("all blend modes, plane extremes, idle bursts and one long output hold.");
    if (n_err == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
